// ----- sv/stag_pkg.sv -----
// Shared types and constants of the strided tensor address generator.
// No dependencies; imported by every module of the block.
package stag_pkg;

  localparam int NDIM       = 4;
  localparam int SIZE_W     = 12;
  localparam int STRIDE_W   = 32;
  localparam int OFFSET_W   = 46;
  localparam int INDEX_W    = 48;
  localparam int PROD_W     = SIZE_W + STRIDE_W;
  localparam int PSUM_W     = PROD_W + 1;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic [SIZE_W-1:0]   dim_size_t;
  typedef logic [SIZE_W-1:0]   coord_t;
  typedef logic [STRIDE_W-1:0] stride_t;
  typedef logic [INDEX_W-1:0]  index_t;

  // Register map, one 32-bit word each
  typedef enum logic [2:0] {
    REG_DIM0_SIZE   = 3'd0,
    REG_DIM1_SIZE   = 3'd1,
    REG_DIM2_SIZE   = 3'd2,
    REG_DIM3_SIZE   = 3'd3,
    REG_DIM0_STRIDE = 3'd4,
    REG_DIM1_STRIDE = 3'd5,
    REG_DIM2_STRIDE = 3'd6,
    REG_DIM3_STRIDE = 3'd7
  } cfg_reg_t;

  // Index 0 is the outermost dimension
  typedef struct packed {
    dim_size_t [NDIM-1:0] size;
    stride_t   [NDIM-1:0] stride;
  } tensor_cfg_t;

  // One element as issued by the coordinate walker
  typedef struct packed {
    coord_t [NDIM-1:0] coord;
    index_t            index;
    logic              last;
  } step_t;

endpackage

// ----- sv/stag_cfg_regs.sv -----
// APB-style register file holding dimension sizes and strides.
// Depends on stag_pkg.
module stag_cfg_regs
  import stag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output tensor_cfg_t           cfg
);

  dim_size_t size_r [NDIM];
  stride_t   stride_r [NDIM];
  cfg_reg_t  reg_sel;
  logic      wr_en;

  assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NDIM; d++) begin
        size_r[d]   <= SIZE_W'(1);
        stride_r[d] <= STRIDE_W'(1);
      end
    end else if (wr_en) begin
      case (reg_sel)
        REG_DIM0_SIZE:   size_r[0]   <= pwdata[SIZE_W-1:0];
        REG_DIM1_SIZE:   size_r[1]   <= pwdata[SIZE_W-1:0];
        REG_DIM2_SIZE:   size_r[2]   <= pwdata[SIZE_W-1:0];
        REG_DIM3_SIZE:   size_r[3]   <= pwdata[SIZE_W-1:0];
        REG_DIM0_STRIDE: stride_r[0] <= pwdata[STRIDE_W-1:0];
        REG_DIM1_STRIDE: stride_r[1] <= pwdata[STRIDE_W-1:0];
        REG_DIM2_STRIDE: stride_r[2] <= pwdata[STRIDE_W-1:0];
        REG_DIM3_STRIDE: stride_r[3] <= pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIM0_SIZE:   prdata = CFG_DATA_W'(size_r[0]);
      REG_DIM1_SIZE:   prdata = CFG_DATA_W'(size_r[1]);
      REG_DIM2_SIZE:   prdata = CFG_DATA_W'(size_r[2]);
      REG_DIM3_SIZE:   prdata = CFG_DATA_W'(size_r[3]);
      REG_DIM0_STRIDE: prdata = CFG_DATA_W'(stride_r[0]);
      REG_DIM1_STRIDE: prdata = CFG_DATA_W'(stride_r[1]);
      REG_DIM2_STRIDE: prdata = CFG_DATA_W'(stride_r[2]);
      REG_DIM3_STRIDE: prdata = CFG_DATA_W'(stride_r[3]);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      cfg.size[d]   = size_r[d];
      cfg.stride[d] = stride_r[d];
    end
  end

endmodule

// ----- sv/stag_coord_walk.sv -----
// Coordinate and element counter state with the carry-chain advance.
// Depends on stag_pkg.
module stag_coord_walk
  import stag_pkg::*;
#(
  parameter int ACTIVE_DIMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tensor_cfg_t cfg,
  input  logic        accept,
  input  logic        restart,
  output step_t       step
);

  localparam int FirstDim = NDIM - ACTIVE_DIMS;

  coord_t coord_r   [NDIM];
  coord_t coord_nxt [NDIM];
  coord_t coord_cur [NDIM];
  index_t cnt_r;
  index_t cnt_nxt;
  index_t cnt_cur;
  logic [NDIM-1:0] dim_final;
  logic            last;

  always_comb begin
    logic [SIZE_W:0] size_eff;
    logic            carry;
    size_eff = '0;
    carry    = 1'b1;
    for (int d = 0; d < NDIM; d++) begin
      coord_cur[d] = restart ? '0 : coord_r[d];
      size_eff     = (cfg.size[d] == '0) ? (SIZE_W+1)'(1) : {1'b0, cfg.size[d]};
      // inactive outer dimensions never block the end of a pass
      dim_final[d] = (d < FirstDim) || (({1'b0, coord_cur[d]} + (SIZE_W+1)'(1)) >= size_eff);
    end
    last = &dim_final;
    // innermost dimension moves fastest, carry outward
    for (int d = NDIM - 1; d >= 0; d--) begin
      if (last || d < FirstDim) begin
        coord_nxt[d] = '0;
      end else if (carry) begin
        coord_nxt[d] = dim_final[d] ? '0 : coord_cur[d] + SIZE_W'(1);
      end else begin
        coord_nxt[d] = coord_cur[d];
      end
      carry = carry & dim_final[d];
    end
    cnt_cur = restart ? '0 : cnt_r;
    cnt_nxt = last ? '0 : cnt_cur + INDEX_W'(1);
  end

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      step.coord[d] = (d < FirstDim) ? '0 : coord_cur[d];
    end
    step.index = cnt_cur;
    step.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NDIM; d++) begin
        coord_r[d] <= '0;
      end
      cnt_r <= '0;
    end else if (accept) begin
      for (int d = 0; d < NDIM; d++) begin
        coord_r[d] <= coord_nxt[d];
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sv/stag_offset_pipe.sv -----
// Three-stage offset pipeline: products, pair sums, final sum and output.
// Depends on stag_pkg.
module stag_offset_pipe
  import stag_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  tensor_cfg_t         cfg,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                accept,
  input  step_t               step,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OFFSET_W-1:0] out_source_offset,
  output index_t              out_dest_index,
  output logic                out_last_of_pass
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic [PROD_W-1:0] prod_r [NDIM];
  index_t            idx1_r;
  logic              last1_r;

  logic [PSUM_W-1:0] psum_lo_r, psum_hi_r;
  index_t            idx2_r;
  logic              last2_r;

  logic [OFFSET_W-1:0] offset_r;
  index_t              idx3_r;
  logic                last3_r;

  // a stage moves when its successor is empty or moving
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int d = 0; d < NDIM; d++) begin
        prod_r[d] <= PROD_W'(step.coord[d]) * PROD_W'(cfg.stride[d]);
      end
      idx1_r  <= step.index;
      last1_r <= step.last;
    end
    if (v1_r && en2) begin
      psum_lo_r <= PSUM_W'(prod_r[0]) + PSUM_W'(prod_r[1]);
      psum_hi_r <= PSUM_W'(prod_r[2]) + PSUM_W'(prod_r[3]);
      idx2_r    <= idx1_r;
      last2_r   <= last1_r;
    end
    if (v2_r && en3) begin
      offset_r <= OFFSET_W'(psum_lo_r) + OFFSET_W'(psum_hi_r);
      idx3_r   <= idx2_r;
      last3_r  <= last2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_source_offset = offset_r;
  assign out_dest_index    = idx3_r;
  assign out_last_of_pass  = last3_r;

endmodule

// ----- sv/strided_tensor_address_generator_unit.sv -----
// Strided tensor address generator: one gather address per accepted transfer.
// Throughput: one transfer per cycle while out_stall is low, set by the
// three-stage multiply/add pipeline behind the walker.
// Reset (rst_n low, synchronous): coordinates and element counter go to zero,
// sizes and strides go to 1, the pipeline empties.
module strided_tensor_address_generator_unit
  import stag_pkg::*;
#(
  parameter int MAX_DIMS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OFFSET_W-1:0]   out_source_offset,
  output logic [INDEX_W-1:0]    out_dest_index,
  output logic                  out_last_of_pass,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Clamp the rank to what the datapath holds; outer dimensions beyond it
  // behave as size 1 with coordinate 0.
  localparam int ActiveDims = (MAX_DIMS > NDIM) ? NDIM :
                              ((MAX_DIMS < 1) ? 1 : MAX_DIMS);

  tensor_cfg_t cfg;
  step_t       step;
  logic        accept;

  // Sizes and strides; the user must write them only while the block is idle (the block does not enforce this).
  stag_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Walker: presents the current element (after restart) and advances its
  // coordinates and counter on every input transfer.
  stag_coord_walk #(
    .ACTIVE_DIMS (ActiveDims)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .restart (in_restart),
    .step    (step)
  );

  // Offset pipeline: multiply each coordinate by its stride, then reduce.
  // Bubbles collapse, so new transfers are taken while a result waits, until the pipeline is full.
  stag_offset_pipe u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .accept            (accept),
    .step              (step),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_source_offset (out_source_offset),
    .out_dest_index    (out_dest_index),
    .out_last_of_pass  (out_last_of_pass)
  );

endmodule
